>>> design/btpc_pkg.sv
// Shared types and constants for the barometer compensation pipeline.
package btpc_pkg;

    localparam logic [20:0] RAW_FULL_SCALE = 21'd1048576;
    localparam logic [32:0] FINE_OFFSET    = 33'd128000;
    localparam logic [11:0] PRESS_SCALE    = 12'd3125;
    localparam logic [63:0] PRESS_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [31:0] TEMP_ROUND     = 32'd128;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coeffs_t;

    // One classified beat handed from the front part to the back part.
    typedef struct packed {
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic        negate;
        logic        zero;
        logic [31:0] temp;
    } fb_item_t;

endpackage

>>> design/btpc_front.sv
// Front part: temperature compensation and pressure dividend/divisor preparation.
module btpc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  btpc_pkg::coeffs_t coeffs,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [19:0]       raw_temperature,
    input  logic [19:0]       raw_pressure,
    output logic              item_valid,
    output btpc_pkg::fb_item_t item,
    input  logic              item_ready
);
    import btpc_pkg::*;

    localparam int STAGES = 13;

    logic [STAGES-1:0] vld_reg;
    logic              adv;

    logic signed [17:0] d1_reg, d1_next;
    logic signed [16:0] d2_reg, d2_next;
    logic signed [33:0] pa_reg, pa_next;
    logic signed [33:0] pb_reg, pb_next;
    logic [31:0]        tv1_reg, tv1_next;
    logic signed [19:0] sq;
    logic signed [35:0] pc_reg, pc_next;
    logic [31:0]        fine_reg, fine_next;
    logic signed [32:0] x_reg, x_next;
    logic signed [65:0] xx_full;
    logic [62:0]        xx_reg, xx_next;
    logic signed [48:0] xp5_reg, xp5_next, xp5b_reg, xp5c_reg;
    logic signed [48:0] xp2_reg, xp2_next, xp2b_reg, xp2c_reg;
    logic signed [48:0] l6_reg, l6_next, l3_reg, l3_next;
    logic signed [47:0] h6_reg, h6_next, h3_reg, h3_next;
    logic [63:0]        s6_reg, s6_next, s3_reg, s3_next;
    logic [63:0]        v2_reg, v2_next, a_reg, a_next;
    logic [63:0]        n0_reg, n0_next;
    logic [47:0]        pl_reg, pl_next;
    logic [31:0]        ph_reg, ph_next;
    logic [63:0]        d_reg, d_next, d12_reg;
    logic [43:0]        nl_reg, nl_next;
    logic [31:0]        nh_reg, nh_next;
    logic [63:0]        nn_reg, nn_next;
    logic [31:0]        temp_next;
    logic [31:0]        temp_reg [5:12];
    logic [20:0]        np_reg [1:9];
    logic [20:0]        np_next;
    fb_item_t           item_reg, item_next;

    assign adv        = !vld_reg[STAGES-1] || item_ready;
    assign in_stall   = !adv;
    assign item_valid = vld_reg[STAGES-1];
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        // temperature, 32-bit wrapping
        d1_next   = {1'b0, raw_temperature[19:3]} - {1'b0, coeffs.t1, 1'b0};
        d2_next   = {1'b0, raw_temperature[19:4]} - {1'b0, coeffs.t1};
        np_next   = RAW_FULL_SCALE - {1'b0, raw_pressure};
        pa_next   = d1_reg * coeffs.t2;
        pb_next   = d2_reg * d2_reg;
        tv1_next  = 32'($signed(pa_reg[31:0]) >>> 11);
        sq        = 20'($signed(pb_reg[31:0]) >>> 12);
        pc_next   = sq * coeffs.t3;
        fine_next = tv1_reg + 32'($signed(pc_reg[31:0]) >>> 14);
        temp_next = 32'($signed(fine_reg + {fine_reg[29:0], 2'b00} + TEMP_ROUND) >>> 8);
        x_next    = {fine_reg[31], fine_reg} - FINE_OFFSET;

        // pressure polynomial, 64-bit wrapping
        xx_full   = x_reg * x_reg;
        xx_next   = xx_full[62:0];
        xp5_next  = x_reg * coeffs.p5;
        xp2_next  = x_reg * coeffs.p2;
        l6_next   = $signed({1'b0, xx_reg[31:0]}) * coeffs.p6;
        h6_next   = $signed({1'b0, xx_reg[62:32]}) * coeffs.p6;
        l3_next   = $signed({1'b0, xx_reg[31:0]}) * coeffs.p3;
        h3_next   = $signed({1'b0, xx_reg[62:32]}) * coeffs.p3;
        s6_next   = {{15{l6_reg[48]}}, l6_reg} + {h6_reg[31:0], 32'h0};
        s3_next   = {{15{l3_reg[48]}}, l3_reg} + {h3_reg[31:0], 32'h0};
        v2_next   = s6_reg + {xp5c_reg[46:0], 17'h0}
                  + {{13{coeffs.p4[15]}}, coeffs.p4, 35'h0};
        a_next    = PRESS_BIAS + 64'($signed(s3_reg) >>> 8)
                  + {{3{xp2c_reg[48]}}, xp2c_reg, 12'h0};
        n0_next   = {12'h0, np_reg[9], 31'h0} - v2_reg;
        pl_next   = a_reg[31:0] * coeffs.p1;
        ph_next   = 32'(a_reg[63:32] * {16'h0, coeffs.p1});
        d_next    = 64'($signed({16'h0, pl_reg} + {ph_reg, 32'h0}) >>> 33);
        nl_next   = n0_reg[31:0] * PRESS_SCALE;
        nh_next   = 32'(n0_reg[63:32] * {20'h0, PRESS_SCALE});
        nn_next   = {20'h0, nl_reg} + {nh_reg, 32'h0};

        // classify: magnitudes, quotient sign, zero divisor
        item_next.dividend = nn_reg[63] ? (64'h0 - nn_reg) : nn_reg;
        item_next.divisor  = d12_reg[63] ? (64'h0 - d12_reg) : d12_reg;
        item_next.negate   = nn_reg[63] ^ d12_reg[63];
        item_next.zero     = (d12_reg == 64'h0);
        item_next.temp     = temp_reg[12];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg   <= d1_next;
            d2_reg   <= d2_next;
            np_reg[1] <= np_next;
            for (int k = 2; k <= 9; k++)
            begin
                np_reg[k] <= np_reg[k-1];
            end
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            tv1_reg  <= tv1_next;
            pc_reg   <= pc_next;
            fine_reg <= fine_next;
            temp_reg[5] <= temp_next;
            for (int k = 6; k <= 12; k++)
            begin
                temp_reg[k] <= temp_reg[k-1];
            end
            x_reg    <= x_next;
            xx_reg   <= xx_next;
            xp5_reg  <= xp5_next;
            xp2_reg  <= xp2_next;
            xp5b_reg <= xp5_reg;
            xp5c_reg <= xp5b_reg;
            xp2b_reg <= xp2_reg;
            xp2c_reg <= xp2b_reg;
            l6_reg   <= l6_next;
            h6_reg   <= h6_next;
            l3_reg   <= l3_next;
            h3_reg   <= h3_next;
            s6_reg   <= s6_next;
            s3_reg   <= s3_next;
            v2_reg   <= v2_next;
            a_reg    <= a_next;
            n0_reg   <= n0_next;
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            d_reg    <= d_next;
            nl_reg   <= nl_next;
            nh_reg   <= nh_next;
            nn_reg   <= nn_next;
            d12_reg  <= d_reg;
            item_reg <= item_next;
        end
    end

endmodule

>>> design/btpc_queue.sv
// Short queue between the front and back parts.
module btpc_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  btpc_pkg::fb_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output btpc_pkg::fb_item_t pop_item
);
    import btpc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    fb_item_t         mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ((wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? ((rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/btpc_back.sv
// Back part: pipelined signed division and pressure correction terms.
module btpc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  btpc_pkg::coeffs_t  coeffs,
    input  logic               item_valid,
    output logic               item_ready,
    input  btpc_pkg::fb_item_t item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] temperature_centi,
    output logic [31:0]        pressure_q24_8,
    output logic               divisor_zero
);
    import btpc_pkg::*;

    localparam int DIV_STEPS = 64;
    localparam int POST      = 6;

    logic                 adv;
    logic [DIV_STEPS:0]   dv_vld_reg;
    logic [63:0]          dv_rem_reg  [0:DIV_STEPS];
    logic [63:0]          dv_quo_reg  [0:DIV_STEPS];
    logic [63:0]          dv_dsr_reg  [0:DIV_STEPS];
    logic                 dv_neg_reg  [0:DIV_STEPS];
    logic                 dv_zero_reg [0:DIV_STEPS];
    logic [31:0]          dv_temp_reg [0:DIV_STEPS];
    logic [64:0]          dv_trial    [0:DIV_STEPS-1];
    logic [64:0]          dv_diff     [0:DIV_STEPS-1];
    logic [63:0]          dv_rem_next [0:DIV_STEPS-1];
    logic [63:0]          dv_quo_next [0:DIV_STEPS-1];

    logic [POST-1:0]      post_vld_reg;
    logic                 post_zero_reg [0:POST-1];
    logic [31:0]          post_temp_reg [0:POST-1];

    logic [63:0]          q1_reg, q1_next, q2_reg, q3_reg, q4_reg, q5_reg;
    logic [63:0]          ps;
    logic [63:0]          ll_reg, ll_next;
    logic [31:0]          lh_reg, lh_next;
    logic signed [48:0]   ql8_reg, ql8_next;
    logic [31:0]          qh8_reg, qh8_next;
    logic [63:0]          s_reg, s_next;
    logic [63:0]          bsum;
    logic [63:0]          b3_reg, b3_next, b4_reg, b5_reg;
    logic signed [48:0]   sl9_reg, sl9_next;
    logic [31:0]          sh9_reg, sh9_next;
    logic [63:0]          asum;
    logic [63:0]          a5_reg, a5_next;
    logic [63:0]          tsum_reg, tsum_next;
    logic [31:0]          press_next;

    logic                 out_valid_reg;
    logic [31:0]          out_temp_reg;
    logic [31:0]          out_press_reg;
    logic                 out_zero_reg;

    assign adv               = !out_valid_reg || !out_stall;
    assign item_ready        = adv;
    assign out_valid         = out_valid_reg;
    assign temperature_centi = out_temp_reg;
    assign pressure_q24_8    = out_press_reg;
    assign divisor_zero      = out_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg    <= '0;
            post_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_vld_reg    <= {dv_vld_reg[DIV_STEPS-1:0], item_valid};
            post_vld_reg  <= {post_vld_reg[POST-2:0], dv_vld_reg[DIV_STEPS]};
            out_valid_reg <= post_vld_reg[POST-1];
        end
    end

    // one restoring quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dv_trial[k]    = {dv_rem_reg[k], dv_quo_reg[k][63]};
            dv_diff[k]     = dv_trial[k] - {1'b0, dv_dsr_reg[k]};
            dv_rem_next[k] = dv_diff[k][64] ? dv_trial[k][63:0] : dv_diff[k][63:0];
            dv_quo_next[k] = {dv_quo_reg[k][62:0], !dv_diff[k][64]};
        end
    end

    always_comb
    begin
        q1_next  = dv_neg_reg[DIV_STEPS] ? (64'h0 - dv_quo_reg[DIV_STEPS])
                                         : dv_quo_reg[DIV_STEPS];
        ps       = 64'($signed(q1_reg) >>> 13);
        ll_next  = ps[31:0] * ps[31:0];
        lh_next  = 32'(ps[31:0] * ps[63:32]);
        ql8_next = $signed({1'b0, q1_reg[31:0]}) * coeffs.p8;
        qh8_next = 32'(q1_reg[63:32] * {{16{coeffs.p8[15]}}, coeffs.p8});
        s_next   = ll_reg + {lh_reg[30:0], 1'b0, 32'h0};
        bsum     = {{15{ql8_reg[48]}}, ql8_reg} + {qh8_reg, 32'h0};
        b3_next  = 64'($signed(bsum) >>> 19);
        sl9_next = $signed({1'b0, s_reg[31:0]}) * coeffs.p9;
        sh9_next = 32'(s_reg[63:32] * {{16{coeffs.p9[15]}}, coeffs.p9});
        asum     = {{15{sl9_reg[48]}}, sl9_reg} + {sh9_reg, 32'h0};
        a5_next  = 64'($signed(asum) >>> 25);
        tsum_next = q5_reg + a5_reg + b5_reg;
        press_next = post_zero_reg[POST-1] ? 32'h0
                   : 32'($signed(tsum_reg) >>> 8)
                     + {{12{coeffs.p7[15]}}, coeffs.p7, 4'h0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0]  <= 64'h0;
            dv_quo_reg[0]  <= item.dividend;
            dv_dsr_reg[0]  <= item.divisor;
            dv_neg_reg[0]  <= item.negate;
            dv_zero_reg[0] <= item.zero;
            dv_temp_reg[0] <= item.temp;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_rem_reg[k+1]  <= dv_rem_next[k];
                dv_quo_reg[k+1]  <= dv_quo_next[k];
                dv_dsr_reg[k+1]  <= dv_dsr_reg[k];
                dv_neg_reg[k+1]  <= dv_neg_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_temp_reg[k+1] <= dv_temp_reg[k];
            end

            post_zero_reg[0] <= dv_zero_reg[DIV_STEPS];
            post_temp_reg[0] <= dv_temp_reg[DIV_STEPS];
            for (int k = 1; k < POST; k++)
            begin
                post_zero_reg[k] <= post_zero_reg[k-1];
                post_temp_reg[k] <= post_temp_reg[k-1];
            end

            q1_reg   <= q1_next;
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            ql8_reg  <= ql8_next;
            qh8_reg  <= qh8_next;
            q2_reg   <= q1_reg;
            s_reg    <= s_next;
            b3_reg   <= b3_next;
            q3_reg   <= q2_reg;
            sl9_reg  <= sl9_next;
            sh9_reg  <= sh9_next;
            b4_reg   <= b3_reg;
            q4_reg   <= q3_reg;
            a5_reg   <= a5_next;
            b5_reg   <= b4_reg;
            q5_reg   <= q4_reg;
            tsum_reg <= tsum_next;

            out_temp_reg  <= post_temp_reg[POST-1];
            out_press_reg <= press_next;
            out_zero_reg  <= post_zero_reg[POST-1];
        end
    end

endmodule

>>> design/baro_temp_pressure_compensate.sv
// Top level of the barometer temperature and pressure compensation block.
//
// Takes one pair of raw 20-bit readings per beat and returns the compensated
// temperature (0.01 degC) and pressure (Pa, unsigned Q24.8) from the twelve
// calibration coefficients loaded through the write port. Accepts a new beat
// every clock cycle while in_stall is low. A beat passes in turn through the
// 13-stage front part (temperature and 64-bit polynomial built from 32-bit
// partial products), the queue, the 65-stage divider (a load stage and 64
// one-bit-per-stage quotient stages) and the 7-stage correction and output
// stage of the back part. A zero divisor drives the pressure to 0 and raises
// divisor_zero; the temperature is still valid.
// Write coefficients only while no beat is in flight.
module baro_temp_pressure_compensate #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] temperature_centi,
    output logic [31:0]        pressure_q24_8,
    output logic               divisor_zero
);
    import btpc_pkg::*;

    typedef enum logic [1:0] {
        REG_TEMP_COEFFS  = 2'd0,
        REG_PRESS_LOW    = 2'd1,
        REG_PRESS_HIGH   = 2'd2,
        REG_PRESS_NINE   = 2'd3
    } cfg_reg_t;

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;
    coeffs_t     coeffs;

    logic        fq_valid, fq_ready;
    fb_item_t    fq_item;
    logic        qb_valid, qb_ready;
    fb_item_t    qb_item;

    // Hold the coefficient registers; a write lands on the indexed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_wdata[47:0];
                REG_PRESS_LOW:   press_low_reg   <= cfg_wdata;
                REG_PRESS_HIGH:  press_high_reg  <= cfg_wdata;
                REG_PRESS_NINE:  press_nine_reg  <= cfg_wdata[15:0];
                default:         press_nine_reg  <= press_nine_reg;
            endcase
        end
    end

    // Unpack the coefficient fields once for both parts.
    assign coeffs.t1 = temp_coeffs_reg[15:0];
    assign coeffs.t2 = temp_coeffs_reg[31:16];
    assign coeffs.t3 = temp_coeffs_reg[47:32];
    assign coeffs.p1 = press_low_reg[15:0];
    assign coeffs.p2 = press_low_reg[31:16];
    assign coeffs.p3 = press_low_reg[47:32];
    assign coeffs.p4 = press_low_reg[63:48];
    assign coeffs.p5 = press_high_reg[15:0];
    assign coeffs.p6 = press_high_reg[31:16];
    assign coeffs.p7 = press_high_reg[47:32];
    assign coeffs.p8 = press_high_reg[63:48];
    assign coeffs.p9 = press_nine_reg;

    // Front: accept a beat, build temperature, dividend and divisor.
    btpc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .coeffs          (coeffs),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .item_valid      (fq_valid),
        .item            (fq_item),
        .item_ready      (fq_ready)
    );

    // Queue: let the front keep going while the back drains a stall.
    btpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // Back: divide, add the correction terms, hold the result beat.
    btpc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .coeffs            (coeffs),
        .item_valid        (qb_valid),
        .item_ready        (qb_ready),
        .item              (qb_item),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .temperature_centi (temperature_centi),
        .pressure_q24_8    (pressure_q24_8),
        .divisor_zero      (divisor_zero)
    );

endmodule

>>> design/btpc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
module btpc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] temperature_centi,
    input logic [31:0]        pressure_q24_8,
    input logic               divisor_zero
);
    logic [7:0] outstanding_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 8'(in_acc) - 8'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature_centi)
            && $stable(pressure_q24_8) && $stable(divisor_zero))
        else $error("result beat changed while stalled");

    a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divisor_zero |-> pressure_q24_8 == 32'h0)
        else $error("zero divisor with nonzero pressure");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != 8'h0)
        else $error("result beat without an accepted input beat");

    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || !out_stall |=> !in_stall)
        else $error("input stalled although the output side was draining");

endmodule

bind baro_temp_pressure_compensate btpc_checker u_checker (.*);
